// ----- hw/rtl/tgi_pkg.sv -----
`default_nettype none
package tgi_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned YEAR_W = 24;
  localparam int unsigned LEVEL_W = 20;
  localparam int unsigned ENTRY_W = YEAR_W + LEVEL_W;
  localparam int unsigned LOG_W = 21;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // action codes carried in tuser
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // request to the interpolation unit
  typedef struct packed {
    logic              start;
    logic [YEAR_W-1:0]  year_b;
    logic [YEAR_W-1:0]  year_a;
    logic [YEAR_W-1:0]  year_q;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] level_a;
  } interp_req_t;

  // response from the interpolation unit
  typedef struct packed {
    logic              done;
    logic [LEVEL_W-1:0] level;
  } interp_rsp_t;

  typedef logic [31:0] exp_tbl_t [17];

  // integer square root rounded down
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bits;
    logic [63:0] vv;
    res = '0;
    bits = 64'd1 << 62;
    vv = v;
    for (int s = 0; s < 32; s++) begin
      if (bits > vv) bits = bits >> 2;
    end
    for (int s = 0; s < 32; s++) begin
      if (bits != 0) begin
        if (vv >= res + bits) begin
          vv = vv - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
    end
    return res;
  endfunction

  // 2^(2^-k) in q2.30 for k = 0..16
  function automatic exp_tbl_t gen_exp_tbl();
    exp_tbl_t t;
    logic [63:0] c;
    c = 64'd1 << 31;
    t[0] = c[31:0];
    for (int k = 1; k < 17; k++) begin
      c = isqrt64(c << 30);
      t[k] = c[31:0];
    end
    return t;
  endfunction

  localparam exp_tbl_t EXP_TBL = gen_exp_tbl();

endpackage
`default_nettype wire

// ----- hw/rtl/tgi_ram.sv -----
`default_nettype none
module tgi_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tgi_interp.sv -----
`default_nettype none
module tgi_interp import tgi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire interp_req_t req_i,
  output interp_rsp_t      rsp_o
);

  typedef enum logic [2:0] {
    I_IDLE, I_DIV, I_LSET, I_LSQ, I_MIX, I_EXP, I_FIN
  } ist_e;

  ist_e               st_q;
  logic [3:0]         step_q;
  logic [YEAR_W:0]    rem_q;
  logic [YEAR_W-1:0]  den_q;
  logic [15:0]        frac_q;
  logic               sel_q;
  logic [LEVEL_W-1:0] lvl_b_q, lvl_a_q;
  logic [31:0]        mant_q;
  logic [15:0]        lfrac_q;
  logic [4:0]         exp_q;
  logic [LOG_W-1:0]   lb_q, la_q, lg_q;
  logic [31:0]        acc_q;
  logic               done_q;
  logic [LEVEL_W-1:0] level_q;

  logic [31:0]        mul_a, mul_b;
  logic [63:0]        prod;
  logic [YEAR_W:0]    rem2;
  logic [LEVEL_W-1:0] lsel;
  logic [4:0]         top_bit;
  logic [32:0]        sq;
  logic               lbit;
  logic [15:0]        lfrac_nx;
  logic               la_ge;
  logic [LOG_W-1:0]   ldiff;
  logic [LOG_W-1:0]   lstep;
  logic [63:0]        shifted;
  logic [33:0]        rounded;

  assign rsp_o = '{done: done_q, level: level_q};

  // shared multiplier operand select
  always_comb begin
    la_ge = la_q >= lb_q;
    ldiff = la_ge ? la_q - lb_q : lb_q - la_q;
    case (st_q)
      I_LSQ: begin
        mul_a = mant_q;
        mul_b = mant_q;
      end
      I_MIX: begin
        mul_a = 32'(ldiff);
        mul_b = 32'(frac_q);
      end
      I_EXP: begin
        mul_a = acc_q;
        mul_b = EXP_TBL[5'(step_q) + 5'd1];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  // datapath helpers
  always_comb begin
    rem2 = {rem_q[YEAR_W-1:0], 1'b0};
    lsel = sel_q ? lvl_a_q : lvl_b_q;
    top_bit = '0;
    for (int b = 0; b < LEVEL_W; b++) begin
      if (lsel[b]) top_bit = 5'(b);
    end
    sq = prod[63:31];
    lbit = sq[32];
    lfrac_nx = {lfrac_q[14:0], lbit};
    lstep = LOG_W'((prod + 64'h8000) >> 16);
    shifted = {32'd0, acc_q} << exp_q;
    rounded = 34'((shifted + 64'h2000_0000) >> 30);
  end

  // sequencer: divide, two logs, mix, exp, round
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= I_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        I_IDLE: begin
          if (req_i.start) begin
            rem_q   <= {1'b0, req_i.year_q - req_i.year_b};
            den_q   <= req_i.year_a - req_i.year_b;
            lvl_b_q <= req_i.level_b;
            lvl_a_q <= req_i.level_a;
            step_q  <= '0;
            st_q    <= I_DIV;
          end
        end
        I_DIV: begin
          if (rem2 >= {1'b0, den_q}) begin
            rem_q  <= rem2 - {1'b0, den_q};
            frac_q <= {frac_q[14:0], 1'b1};
          end else begin
            rem_q  <= rem2;
            frac_q <= {frac_q[14:0], 1'b0};
          end
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            sel_q <= 1'b0;
            st_q  <= I_LSET;
          end
        end
        I_LSET: begin
          exp_q   <= top_bit;
          mant_q  <= 32'(lsel) << (5'd31 - top_bit);
          lfrac_q <= '0;
          step_q  <= '0;
          st_q    <= I_LSQ;
        end
        I_LSQ: begin
          mant_q  <= lbit ? sq[32:1] : sq[31:0];
          lfrac_q <= lfrac_nx;
          step_q  <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            if (!sel_q) begin
              lb_q  <= {exp_q, lfrac_nx};
              sel_q <= 1'b1;
              st_q  <= I_LSET;
            end else begin
              la_q <= {exp_q, lfrac_nx};
              st_q <= I_MIX;
            end
          end
        end
        I_MIX: begin
          lg_q   <= la_ge ? lb_q + lstep : lb_q - lstep;
          acc_q  <= 32'h4000_0000;
          step_q <= '0;
          st_q   <= I_EXP;
        end
        I_EXP: begin
          if (lg_q[4'd15 - step_q]) acc_q <= prod[61:30];
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            exp_q <= lg_q[LOG_W-1:16];
            st_q  <= I_FIN;
          end
        end
        I_FIN: begin
          done_q <= 1'b1;
          if (exp_q > 5'd20 || rounded > 34'(LEVEL_MAX)) begin
            level_q <= LEVEL_MAX;
          end else begin
            level_q <= rounded[LEVEL_W-1:0];
          end
          st_q <= I_IDLE;
        end
        default: st_q <= I_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/table_geometric_interpolator.sv -----
// channel  | dir | tdata                                         | tuser
// s_axis   | in  | entry_year[23:0] entry_level[43:24] query_year[67:44] | action[1:0]
// m_axis   | out | level[19:0]                                   | status[1:0]
//
// one transaction at a time; a clear goes straight to the result, a load scans
// entries and then shifts later entries up to insert a new year, a query scans
// entries and then interpolates (16 divide steps, 2x16 log squarings, 16 exp
// steps; the squarings and exp steps share one 32x32 multiplier). the result
// sits in an output register, so a stalled m_axis holds only the finishing step.
// reset clears the entry count; table contents are not cleared.
`default_nettype none
module table_geometric_interpolator import tgi_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // entry_year, entry_level, query_year, zero pad
  input  wire logic [1:0]  s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // level, zero pad
  output logic      [1:0]  m_axis_tuser   // status
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_SHRD, S_SHWR, S_WRPOS, S_IGO, S_IWAIT, S_OUT
  } state_e;

  state_e             state_q;
  logic [1:0]         act_q;
  logic [YEAR_W-1:0]  ey_q, qy_q;
  logic [LEVEL_W-1:0] el_q;
  logic [CNT_W-1:0]   cnt_q, idx_q, j_q;
  logic [YEAR_W-1:0]  prev_year_q, hit_year_q;
  logic [LEVEL_W-1:0] prev_level_q, hit_level_q;
  logic [LEVEL_W-1:0] res_level_q, m_level_q;
  logic [1:0]         res_status_q, m_status_q;
  logic               m_valid_q;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [YEAR_W-1:0]  rd_year, key;
  logic [LEVEL_W-1:0] rd_level, in_level;
  logic [CNT_W-1:0]   j_dec;
  logic               full, hit_eq, hit_lt;
  interp_req_t        ireq;
  interp_rsp_t        irsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_level_q};
  assign m_axis_tuser  = m_status_q;

  assign rd_year  = ram_rdata[YEAR_W-1:0];
  assign rd_level = ram_rdata[ENTRY_W-1:YEAR_W];
  assign key      = (act_q == ACT_LOAD) ? ey_q : qy_q;
  assign hit_eq   = (rd_year == key);
  assign hit_lt   = (rd_year < key);
  assign full     = (cnt_q == CNT_W'(TABLE_DEPTH));
  assign j_dec    = j_q - 1'b1;
  assign in_level = s_axis_tdata[43:24];

  // table port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q[IDX_W-1:0];
    ram_wdata = {el_q, ey_q};
    ram_raddr = idx_q[IDX_W-1:0];
    case (state_q)
      S_SCMP: ram_we = (act_q == ACT_LOAD) && hit_eq;
      S_SHRD: ram_raddr = j_dec[IDX_W-1:0];
      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IDX_W-1:0];
        ram_wdata = ram_rdata;
      end
      S_WRPOS: ram_we = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  tgi_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ireq = '{start: (state_q == S_IGO), year_b: prev_year_q, year_a: hit_year_q,
                  year_q: qy_q, level_b: prev_level_q, level_a: hit_level_q};

  tgi_interp u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ireq),
    .rsp_o  (irsp)
  );

  // sequencer: scan, insert by shifting, interpolate, hand off result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && state_q != S_OUT) m_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q        <= s_axis_tuser;
            ey_q         <= s_axis_tdata[23:0];
            el_q         <= (in_level == '0) ? LEVEL_W'(1) : in_level;
            qy_q         <= s_axis_tdata[67:44];
            idx_q        <= '0;
            res_level_q  <= '0;
            res_status_q <= STAT_OK;
            case (s_axis_tuser)
              ACT_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_OUT;
              end
              ACT_LOAD, ACT_QUERY: state_q <= S_SRD;
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_SRD: begin
          if (idx_q == cnt_q) begin
            // key beyond the last entry
            if (act_q == ACT_LOAD) begin
              if (full) begin
                res_status_q <= STAT_FULL;
                state_q      <= S_OUT;
              end else begin
                state_q <= S_WRPOS;
              end
            end else begin
              res_status_q <= STAT_RANGE;
              state_q      <= S_OUT;
            end
          end else begin
            state_q <= S_SCMP;
          end
        end
        S_SCMP: begin
          if (hit_lt) begin
            prev_year_q  <= rd_year;
            prev_level_q <= rd_level;
            idx_q        <= idx_q + 1'b1;
            state_q      <= S_SRD;
          end else if (act_q == ACT_LOAD) begin
            if (hit_eq) begin
              state_q <= S_OUT;
            end else if (full) begin
              res_status_q <= STAT_FULL;
              state_q      <= S_OUT;
            end else begin
              j_q     <= cnt_q;
              state_q <= S_SHRD;
            end
          end else if (hit_eq) begin
            res_level_q <= rd_level;
            state_q     <= S_OUT;
          end else if (idx_q == '0) begin
            res_status_q <= STAT_RANGE;
            state_q      <= S_OUT;
          end else begin
            hit_year_q  <= rd_year;
            hit_level_q <= rd_level;
            state_q     <= S_IGO;
          end
        end
        S_SHRD: state_q <= S_SHWR;
        S_SHWR: begin
          j_q     <= j_dec;
          state_q <= (j_dec > idx_q) ? S_SHRD : S_WRPOS;
        end
        S_WRPOS: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_OUT;
        end
        S_IGO: state_q <= S_IWAIT;
        S_IWAIT: begin
          if (irsp.done) begin
            res_level_q <= irsp.level;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q  <= 1'b1;
            m_level_q  <= res_level_q;
            m_status_q <= res_status_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tgi_checker.sv -----
`default_nettype none
module tgi_checker import tgi_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser)))
    else $error("stalled result changed");

  // only successful queries carry a level
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != STAT_OK) |-> (m_axis_tdata == 24'd0))
    else $error("error status with nonzero level");

  // status code three is never produced
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != 2'd3))
    else $error("invalid status");

  // one transaction in work at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

endmodule

bind table_geometric_interpolator tgi_checker u_tgi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- test/table_geometric_interpolator_tb.sv -----
`default_nettype none
module table_geometric_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tgi_pkg::*;

  localparam int unsigned IDLE_LIMIT = 20000;

  // one result transaction as predicted or observed
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [1:0]         status;
  } outcome_t;

  // one stimulus row; has_fixed marks rows whose result is typed in
  typedef struct {
    action_e           act;
    logic [YEAR_W-1:0]  eyear;
    logic [LEVEL_W-1:0] elevel;
    logic [YEAR_W-1:0]  qyear;
    bit                has_fixed;
    outcome_t          fixed;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;  // entry_year, entry_level, query_year, zero pad
  logic [1:0]  s_axis_tuser;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;  // level, zero pad
  logic [1:0]  m_axis_tuser;  // status

  table_geometric_interpolator dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // shadow copy of the breakpoint table
  logic [YEAR_W-1:0]  shadow_year [TABLE_DEPTH];
  logic [LEVEL_W-1:0] shadow_level[TABLE_DEPTH];
  int unsigned        shadow_count;

  outcome_t    pending_results[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned queries_sent, interp_queries;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          stim_done;
  request_t    directed[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // log2 of a raw level, q.16
  function automatic logic [31:0] log2_fixed(input logic [31:0] v);
    logic [31:0] e;
    logic [31:0] fr;
    logic [63:0] m;
    e = 0;
    fr = 0;
    while (e < 31 && (v >> (e + 1)) != 0) e++;
    m = 64'(v) << (31 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      fr = fr << 1;
      if (m >= (64'd1 << 32)) begin
        fr[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (e << 16) | fr;
  endfunction

  // floor square root by bit-serial method
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp2 of a q.16 value, rounded and saturated to a level
  function automatic logic [LEVEL_W-1:0] exp2_fixed(input logic [31:0] lg);
    logic [31:0] n;
    logic [63:0] acc;
    logic [63:0] c;
    logic [63:0] val;
    n = lg >> 16;
    acc = 64'd1 << 30;
    c = 64'd1 << 31;
    for (int k = 1; k <= 16; k++) begin
      c = floor_sqrt(c << 30);
      if (lg[16-k]) acc = (acc * c) >> 30;
    end
    if (n > 20) return LEVEL_MAX;
    val = ((acc << n) + (64'd1 << 29)) >> 30;
    if (val > 64'(LEVEL_MAX)) val = 64'(LEVEL_MAX);
    return val[LEVEL_W-1:0];
  endfunction

  // first slot whose year is not below y
  function automatic int unsigned slot_of(input logic [YEAR_W-1:0] y);
    int unsigned i;
    i = 0;
    while (i < shadow_count && shadow_year[i] < y) i++;
    return i;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic outcome_t apply_request(input request_t r);
    outcome_t o;
    int unsigned p;
    logic [LEVEL_W-1:0] lv;
    logic [63:0] fr;
    logic [31:0] lb, la, lg;
    o = '0;
    case (r.act)
      ACT_CLEAR: shadow_count = 0;
      ACT_LOAD: begin
        p = slot_of(r.eyear);
        lv = (r.elevel == 0) ? 1 : r.elevel;
        if (p < shadow_count && shadow_year[p] == r.eyear) begin
          shadow_level[p] = lv;
        end else if (shadow_count >= TABLE_DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          for (int j = shadow_count; j > p; j--) begin
            shadow_year[j] = shadow_year[j-1];
            shadow_level[j] = shadow_level[j-1];
          end
          shadow_year[p] = r.eyear;
          shadow_level[p] = lv;
          shadow_count++;
        end
      end
      ACT_QUERY: begin
        if (shadow_count == 0 || r.qyear < shadow_year[0] ||
            r.qyear > shadow_year[shadow_count-1]) begin
          o.status = STAT_RANGE;
        end else begin
          p = slot_of(r.qyear);
          if (shadow_year[p] == r.qyear || p == 0) begin
            o.level = shadow_level[p];
          end else begin
            fr = (64'(r.qyear - shadow_year[p-1]) << 16) /
                 64'(shadow_year[p] - shadow_year[p-1]);
            lb = log2_fixed(32'(shadow_level[p-1]));
            la = log2_fixed(32'(shadow_level[p]));
            if (la >= lb) lg = lb + 32'((64'(la - lb) * fr + 64'h8000) >> 16);
            else lg = lb - 32'((64'(lb - la) * fr + 64'h8000) >> 16);
            o.level = exp2_fixed(lg);
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic request_t make_req(input action_e a, input logic [YEAR_W-1:0] ey,
                                        input logic [LEVEL_W-1:0] el,
                                        input logic [YEAR_W-1:0] qy);
    request_t r;
    r.act = a;
    r.eyear = ey;
    r.elevel = el;
    r.qyear = qy;
    r.has_fixed = 1'b0;
    r.fixed = '0;
    return r;
  endfunction

  function automatic request_t fixed_req(input request_t r, input logic [LEVEL_W-1:0] lv,
                                         input status_e st);
    r.has_fixed = 1'b1;
    r.fixed.level = lv;
    r.fixed.status = st;
    return r;
  endfunction

  // short gaps mostly, sometimes long, sometimes none for a stretch
  function automatic int unsigned gap_len();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (d < 55) return 0;
    if (d < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // send one request, hold until accepted, queue its expectation
  task automatic send_request(input request_t r);
    outcome_t o;
    int unsigned g;
    g = gap_len();
    repeat (g) @(negedge clk_i);
    s_axis_tdata = {4'd0, r.qyear, r.elevel, r.eyear};
    s_axis_tuser = r.act;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    o = apply_request(r);
    if (r.has_fixed) o = r.fixed;
    if (r.act == ACT_QUERY) queries_sent++;
    pending_results.push_back(o);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // random breakpoint year, often clustered in a narrow window
  function automatic logic [YEAR_W-1:0] rand_year();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 24'hFFFFFF);
      1: return 24'h07B200 + $urandom_range(0, 24'h004000);
      2: return $urandom_range(0, 16);
      default: return 24'hFFFFFF - $urandom_range(0, 16);
    endcase
  endfunction

  function automatic logic [LEVEL_W-1:0] rand_level();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 20'hFFFFF);
      1: return $urandom_range(0, 4);
      2: return 20'hFFFFF - $urandom_range(0, 3);
      default: return 20'h11800 + $urandom_range(0, 20'h20000);
    endcase
  endfunction

  // stimulus
  initial begin
    request_t r;
    int unsigned sent;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ACT_CLEAR;
    stim_done = 1'b0;
    shadow_count = 0;
    queries_sent = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed rows
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'h07D000), 0, STAT_RANGE));
    directed.push_back(fixed_req(make_req(ACT_LOAD, 24'h07B200, 20'h11800, 0), 0, STAT_OK));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'h07B200), 20'h11800, STAT_OK));
    directed.push_back(make_req(ACT_LOAD, 24'h07D000, 20'h1F400, 0));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'h07C100));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'h07CF80));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'h07B1FF), 0, STAT_RANGE));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'h07D001), 0, STAT_RANGE));
    // overwrite at an existing year
    directed.push_back(make_req(ACT_LOAD, 24'h07D000, 20'h0A000, 0));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'h07C800));
    // zero level stored as the smallest level
    directed.push_back(fixed_req(make_req(ACT_LOAD, 24'hFFFFFF, 20'h00000, 0), 0, STAT_OK));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'hFFFFFF), 1, STAT_OK));
    directed.push_back(make_req(ACT_LOAD, 24'h000000, 20'hFFFFF, 0));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 24'h000000), 20'hFFFFF, STAT_OK));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'h000001));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'hFFFFFE));
    // unused action code
    r = make_req(ACT_CLEAR, 24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF);
    r.act = action_e'(2'd3);
    directed.push_back(fixed_req(r, 0, STAT_OK));
    directed.push_back(make_req(ACT_QUERY, 0, 0, 24'h07C000));
    directed.push_back(fixed_req(make_req(ACT_CLEAR, 24'hFFFFFF, 20'hFFFFF, 24'hFFFFFF),
                                 0, STAT_OK));
    directed.push_back(fixed_req(make_req(ACT_QUERY, 0, 0, 0), 0, STAT_RANGE));
    foreach (directed[i]) send_request(directed[i]);

    // fill the table up, then try one more new year
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_request(make_req(ACT_LOAD, 24'(i * 24'h3F000 + 24'h100), rand_level(), 0));
    send_request(fixed_req(make_req(ACT_LOAD, 24'h000050, 20'h12345, 0), 0, STAT_FULL));
    send_request(make_req(ACT_LOAD, 24'h000100, 20'h00042, 0));
    for (int i = 0; i < 6; i++) send_request(make_req(ACT_QUERY, 0, 0, rand_year()));

    // hold off until everything has drained
    wait (pending_results.size() == 0);
    @(negedge clk_i);

    // random: sessions of clear, loads and queries, with some noise
    sent = 0;
    while (sent < 1400) begin
      int unsigned n_load;
      send_request(make_req(ACT_CLEAR, rand_year(), rand_level(), rand_year()));
      sent++;
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 10);
      for (int i = 0; i < n_load; i++) begin
        send_request(make_req(ACT_LOAD, rand_year(), rand_level(), rand_year()));
        sent++;
      end
      for (int i = $urandom_range(2, 12); i > 0; i--) begin
        if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
          int unsigned p;
          p = $urandom_range(0, shadow_count - 1);
          r = make_req(ACT_QUERY, rand_year(), rand_level(), shadow_year[p]);
          if (p + 1 < shadow_count && $urandom_range(0, 3) != 0)
            r.qyear = shadow_year[p] +
                      24'($urandom_range(0, shadow_year[p+1] - shadow_year[p]));
        end else if ($urandom_range(0, 4) == 0) begin
          r = make_req(action_e'(2'd3), rand_year(), rand_level(), rand_year());
        end else begin
          r = make_req(ACT_QUERY, rand_year(), rand_level(), rand_year());
        end
        send_request(r);
        sent++;
      end
    end
    stim_done = 1'b1;
  end

  // result side: random backpressure and checking
  initial begin
    outcome_t got, want;
    int unsigned g;
    m_axis_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      g = gap_len();
      if ($urandom_range(0, 9) < 3 && g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.level = m_axis_tdata[LEVEL_W-1:0];
        got.status = m_axis_tuser;
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: level %h status %0d", got.level, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.level !== want.level || got.status !== want.status ||
              m_axis_tdata[23:LEVEL_W] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected level %h status %0d, got tdata %h status %0d",
                       results_seen, want.level, want.status, m_axis_tdata, got.status);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  initial begin
    timed_out = 1'b0;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("run covered %0d results, %0d of them queries, over clear/load/query",
             results_seen, queries_sent);
    $display("sessions filled and overflowed the table and hit range edges");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
hw/rtl/tgi_pkg.sv
hw/rtl/tgi_ram.sv
hw/rtl/tgi_interp.sv
hw/rtl/table_geometric_interpolator.sv
hw/rtl/tgi_checker.sv
test/table_geometric_interpolator_tb.sv
